>>> hdl/asp_pkg.sv
package asp_pkg;

  localparam int FIFO_DEPTH = 64;  // power of two, 64..256
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int WADDR_W    = PTR_W - 1;
  localparam int WORDS      = FIFO_DEPTH / 2;
  localparam int CNT_W      = PTR_W + 1;
  localparam int THR_W      = 7;
  localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int ACT_W      = 3;
  localparam int DATA_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int LVL_W      = 10;
  localparam int STEP_W     = 4;
  localparam int WAIT_W     = 14;
  localparam int LEFT_W     = 12;
  localparam int RATE_W     = 6;

  localparam logic [THR_W-1:0] THR_RST = 7'd48;

  localparam int LVL_MAX      = 255;
  localparam int LVL_MIN      = -256;
  localparam int STEP_MAX     = 15;
  localparam int SILENCE_UNIT = 160;
  localparam int BLOCK_LEN    = 256;
  localparam int AUDIO_SHIFT  = 7;

  // control word bits
  localparam int CW_BUSY   = 15;
  localparam int CW_IRQ_EN = 14;
  localparam int CW_ENABLE = 11;
  localparam int CW_VOL_HI = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_CTRL_WR = 3'd1,
    ACT_DATA_WR = 3'd2,
    ACT_CTRL_RD = 3'd3,
    ACT_DATA_RD = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    CMD_SILENCE = 2'b00,
    CMD_BLOCK   = 2'b01,
    CMD_COUNTED = 2'b10,
    CMD_REPEAT  = 2'b11
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NIB,
    S_CMD,
    S_CNT,
    S_RATE,
    S_MUL
  } seq_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] write_value;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]        read_data;
    logic signed [DATA_W-1:0] audio_sample;
    logic                     sample_valid;
    logic                     irq;
  } res_t;

  // delta magnitudes per step state; the upper nibble bit gives the sign
  localparam logic [7:0] DELTA_MAG [16][8] = '{
    '{8'd0, 8'd0,  8'd1,  8'd2,  8'd3,  8'd5,   8'd7,   8'd10 },
    '{8'd0, 8'd1,  8'd2,  8'd3,  8'd4,  8'd6,   8'd8,   8'd13 },
    '{8'd0, 8'd1,  8'd2,  8'd4,  8'd5,  8'd7,   8'd10,  8'd15 },
    '{8'd0, 8'd1,  8'd3,  8'd4,  8'd6,  8'd9,   8'd13,  8'd19 },
    '{8'd0, 8'd2,  8'd3,  8'd5,  8'd8,  8'd11,  8'd15,  8'd23 },
    '{8'd0, 8'd2,  8'd4,  8'd7,  8'd10, 8'd14,  8'd19,  8'd29 },
    '{8'd0, 8'd3,  8'd5,  8'd8,  8'd12, 8'd16,  8'd22,  8'd33 },
    '{8'd1, 8'd4,  8'd7,  8'd10, 8'd15, 8'd20,  8'd29,  8'd43 },
    '{8'd1, 8'd4,  8'd8,  8'd13, 8'd18, 8'd25,  8'd35,  8'd53 },
    '{8'd1, 8'd6,  8'd10, 8'd16, 8'd22, 8'd31,  8'd43,  8'd64 },
    '{8'd2, 8'd7,  8'd12, 8'd19, 8'd27, 8'd37,  8'd51,  8'd76 },
    '{8'd2, 8'd9,  8'd16, 8'd24, 8'd34, 8'd46,  8'd64,  8'd96 },
    '{8'd3, 8'd11, 8'd19, 8'd29, 8'd41, 8'd57,  8'd79,  8'd117},
    '{8'd4, 8'd13, 8'd24, 8'd36, 8'd50, 8'd69,  8'd96,  8'd143},
    '{8'd4, 8'd16, 8'd29, 8'd44, 8'd62, 8'd85,  8'd118, 8'd175},
    '{8'd6, 8'd20, 8'd36, 8'd54, 8'd76, 8'd104, 8'd144, 8'd214}
  };

  localparam logic signed [2:0] STEP_MOVE [8] = '{
    -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd2, 3'sd3
  };

  function automatic logic signed [8:0] delta_of(input logic [STEP_W-1:0] step,
                                                 input logic [3:0] nib);
    logic [8:0] mag;
    mag = {1'b0, DELTA_MAG[step][nib[2:0]]};
    return nib[3] ? $signed(9'd0 - mag) : $signed(mag);
  endfunction

endpackage

>>> hdl/asp_if.sv
interface asp_item_if;
  logic                           valid;
  logic                           ready;
  logic [asp_pkg::ACT_W-1:0]      action;
  logic [asp_pkg::DATA_W-1:0]     write_value;

  modport source (output valid, action, write_value, input ready);
  modport sink   (input valid, action, write_value, output ready);
endinterface

interface asp_result_if;
  logic                              valid;
  logic                              ready;
  logic [asp_pkg::DATA_W-1:0]        read_data;
  logic signed [asp_pkg::DATA_W-1:0] audio_sample;
  logic                              sample_valid;
  logic                              irq;

  modport source (output valid, read_data, audio_sample, sample_valid, irq, input ready);
  modport sink   (input valid, read_data, audio_sample, sample_valid, irq, output ready);
endinterface

interface asp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [asp_pkg::THR_W-1:0]     irq_level;

  modport source (output valid, irq_level, input ready);
  modport sink   (input valid, irq_level, output ready);
endinterface

>>> hdl/asp_ram.sv
module asp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/asp_dec.sv
module asp_dec (
  input  logic [asp_pkg::STEP_W-1:0]       step_i,
  input  logic signed [asp_pkg::LVL_W-1:0] lvl_i,
  input  logic [3:0]                       nib_i,
  output logic [asp_pkg::STEP_W-1:0]       step_o,
  output logic signed [asp_pkg::LVL_W-1:0] lvl_o
);

  logic signed [8:0]              delta;
  logic signed [asp_pkg::LVL_W:0] sum;
  logic signed [2:0]              mv;
  logic signed [5:0]              st;

  always_comb begin
    delta = asp_pkg::delta_of(step_i, nib_i);
    sum   = $signed({lvl_i[asp_pkg::LVL_W-1], lvl_i}) + $signed({{2{delta[8]}}, delta});
    if (sum > $signed(11'(asp_pkg::LVL_MAX))) begin
      lvl_o = $signed(10'(asp_pkg::LVL_MAX));
    end else if (sum < $signed(11'(asp_pkg::LVL_MIN))) begin
      lvl_o = $signed(10'(asp_pkg::LVL_MIN));
    end else begin
      lvl_o = sum[asp_pkg::LVL_W-1:0];
    end

    mv = asp_pkg::STEP_MOVE[nib_i[2:0]];
    st = $signed({2'b00, step_i}) + $signed({{3{mv[2]}}, mv});
    if (st < 6'sd0) begin
      step_o = '0;
    end else if (st > $signed(6'(asp_pkg::STEP_MAX))) begin
      step_o = 4'(asp_pkg::STEP_MAX);
    end else begin
      step_o = st[asp_pkg::STEP_W-1:0];
    end
  end

endmodule

>>> hdl/asp_core.sv
module asp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  asp_pkg::item_t             item_i,
  input  logic [asp_pkg::THR_W-1:0]  thresh_i,
  output logic                       idle_o,
  output logic                       done_o,
  output asp_pkg::res_t              res_o
);

  localparam int PW = asp_pkg::PTR_W;

  asp_pkg::seq_e state_q, state_d;

  logic                              empty_q, empty_d;
  logic [PW-1:0]                     rp_q, rp_d;
  logic [PW-1:0]                     wp_q, wp_d;
  logic [asp_pkg::DATA_W-1:0]        cw_q, cw_d;
  logic [asp_pkg::STEP_W-1:0]        step_q, step_d;
  logic signed [asp_pkg::LVL_W-1:0]  lvl_q, lvl_d;
  logic [4:0]                        pend_q, pend_d;
  logic [asp_pkg::WAIT_W-1:0]        wait_q, wait_d;
  logic [asp_pkg::LEFT_W-1:0]        left_q, left_d;
  logic [asp_pkg::RATE_W-1:0]        rate_q, rate_d;
  logic [asp_pkg::BYTE_W-1:0]        cmd_q, cmd_d;
  logic signed [asp_pkg::DATA_W-1:0] audio_q, audio_d;
  logic                              sel_q, sel_d;
  logic                              zero_q, zero_d;

  logic                              ram_we;
  logic                              pop;
  logic [asp_pkg::DATA_W-1:0]        ram_rdata;
  logic [asp_pkg::BYTE_W-1:0]        pbyte;
  logic [PW-1:0]                     rp_inc;
  logic [PW-1:0]                     lvl_diff;
  logic [PW-1:0]                     fill_diff;
  logic [asp_pkg::CNT_W-1:0]         cnt;
  logic [3:0]                        nib;
  logic [asp_pkg::STEP_W-1:0]        dec_step;
  logic signed [asp_pkg::LVL_W-1:0]  dec_lvl;
  logic signed [asp_pkg::LVL_W-1:0]  lvl_shr;
  logic signed [asp_pkg::DATA_W-1:0] audio_now;
  logic [8:0]                        cnt_base;
  logic [3:0]                        rep;
  logic                              is_tick;

  asp_ram #(
    .WIDTH (asp_pkg::DATA_W),
    .DEPTH (asp_pkg::WORDS)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q[PW-1:1]),
    .wdata_i (item_i.write_value),
    .re_i    (pop),
    .raddr_i (rp_q[PW-1:1]),
    .rdata_o (ram_rdata)
  );

  // even byte address holds the high byte of a written word
  assign pbyte = zero_q ? '0 : (sel_q ? ram_rdata[7:0] : ram_rdata[15:8]);
  assign nib   = (state_q == asp_pkg::S_NIB) ? pbyte[7:4] : pend_q[3:0];

  asp_dec u_dec (
    .step_i (step_q),
    .lvl_i  (lvl_q),
    .nib_i  (nib),
    .step_o (dec_step),
    .lvl_o  (dec_lvl)
  );

  // arithmetic shift floors, matching the rounding of the sample scaling
  assign lvl_shr   = lvl_q >>> cw_q[asp_pkg::CW_VOL_HI:0];
  assign audio_now = $signed({{(asp_pkg::DATA_W-asp_pkg::LVL_W){lvl_shr[asp_pkg::LVL_W-1]}},
                              lvl_shr} << asp_pkg::AUDIO_SHIFT);

  assign cnt_base = {1'b0, pbyte} + 9'd1;
  assign rep      = {1'b0, cmd_q[2:0]} + 4'd1;
  assign rp_inc   = rp_q + PW'(1);
  assign lvl_diff = rp_q - wp_q;

  always_comb begin
    state_d = state_q;
    empty_d = empty_q;
    rp_d    = rp_q;
    wp_d    = wp_q;
    cw_d    = cw_q;
    step_d  = step_q;
    lvl_d   = lvl_q;
    pend_d  = pend_q;
    wait_d  = wait_q;
    left_d  = left_q;
    rate_d  = rate_q;
    cmd_d   = cmd_q;
    audio_d = audio_q;
    sel_d   = sel_q;
    zero_d  = zero_q;
    ram_we  = 1'b0;
    pop     = 1'b0;
    done_o  = 1'b0;
    res_o   = '0;
    is_tick = (state_q != asp_pkg::S_IDLE);

    case (state_q)
      asp_pkg::S_IDLE: begin
        if (accept_i) begin
          is_tick = (item_i.action == asp_pkg::ACT_TICK);
          case (item_i.action)
            asp_pkg::ACT_TICK: begin
              audio_d = audio_now;
              if (!cw_q[asp_pkg::CW_ENABLE]) begin
                done_o = 1'b1;
              end else if (wait_q != '0) begin
                wait_d = wait_q - 14'd1;
                done_o = 1'b1;
              end else if (left_q != '0) begin
                left_d = left_q - 12'd1;
                if (pend_q[4]) begin
                  lvl_d  = dec_lvl;
                  step_d = dec_step;
                  pend_d = '0;
                  wait_d = {{(asp_pkg::WAIT_W-asp_pkg::RATE_W){1'b0}}, rate_q};
                  done_o = 1'b1;
                end else begin
                  pop     = 1'b1;
                  state_d = asp_pkg::S_NIB;
                end
              end else begin
                pop     = 1'b1;
                state_d = asp_pkg::S_CMD;
              end
            end
            asp_pkg::ACT_CTRL_WR: begin
              if (item_i.write_value[asp_pkg::CW_BUSY]) begin
                empty_d = 1'b1;
                rp_d    = '0;
                wp_d    = '0;
                step_d  = '0;
                lvl_d   = '0;
                pend_d  = '0;
                wait_d  = '0;
                left_d  = '0;
                rate_d  = '0;
                cw_d    = {1'b0, item_i.write_value[asp_pkg::CW_BUSY-1:0]};
              end else begin
                cw_d = {cw_q[asp_pkg::CW_BUSY], item_i.write_value[asp_pkg::CW_BUSY-1:0]};
              end
              done_o = 1'b1;
            end
            asp_pkg::ACT_DATA_WR: begin
              if (empty_q) begin
                rp_d    = wp_q;
                empty_d = 1'b0;
              end
              ram_we = 1'b1;
              wp_d   = wp_q + PW'(2);
              done_o = 1'b1;
            end
            asp_pkg::ACT_CTRL_RD: begin
              res_o.read_data = cw_q;
              done_o          = 1'b1;
            end
            asp_pkg::ACT_DATA_RD: begin
              res_o.read_data = empty_q ? 16'(asp_pkg::FIFO_DEPTH - 1)
                                        : {{(asp_pkg::DATA_W-PW){1'b0}}, lvl_diff};
              done_o          = 1'b1;
            end
            default: begin
              done_o = 1'b1;
            end
          endcase
        end
      end
      asp_pkg::S_NIB: begin
        pend_d  = {1'b1, pbyte[3:0]};
        lvl_d   = dec_lvl;
        step_d  = dec_step;
        wait_d  = {{(asp_pkg::WAIT_W-asp_pkg::RATE_W){1'b0}}, rate_q};
        done_o  = 1'b1;
        state_d = asp_pkg::S_IDLE;
      end
      asp_pkg::S_CMD: begin
        cmd_d             = pbyte;
        cw_d[asp_pkg::CW_BUSY] = |pbyte;
        case (pbyte[7:6])
          asp_pkg::CMD_SILENCE: begin
            lvl_d   = '0;
            step_d  = '0;
            wait_d  = 14'(pbyte[5:0]) * 14'(asp_pkg::SILENCE_UNIT);
            done_o  = 1'b1;
            state_d = asp_pkg::S_IDLE;
          end
          asp_pkg::CMD_BLOCK: begin
            rate_d  = pbyte[5:0];
            left_d  = 12'(asp_pkg::BLOCK_LEN);
            done_o  = 1'b1;
            state_d = asp_pkg::S_IDLE;
          end
          asp_pkg::CMD_COUNTED: begin
            rate_d  = pbyte[5:0];
            pop     = 1'b1;
            state_d = asp_pkg::S_CNT;
          end
          default: begin
            pop     = 1'b1;
            state_d = asp_pkg::S_RATE;
          end
        endcase
      end
      asp_pkg::S_CNT: begin
        left_d  = {3'b000, cnt_base};
        done_o  = 1'b1;
        state_d = asp_pkg::S_IDLE;
      end
      asp_pkg::S_RATE: begin
        rate_d  = pbyte[5:0];
        wait_d  = {{(asp_pkg::WAIT_W-asp_pkg::RATE_W){1'b0}}, pbyte[5:0]};
        pop     = 1'b1;
        state_d = asp_pkg::S_MUL;
      end
      asp_pkg::S_MUL: begin
        left_d  = 12'(cnt_base) * 12'(rep);
        done_o  = 1'b1;
        state_d = asp_pkg::S_IDLE;
      end
      default: begin
        state_d = asp_pkg::S_IDLE;
      end
    endcase

    // byte pop: address goes to the RAM now, the byte is picked next cycle
    if (pop) begin
      sel_d  = rp_q[0];
      zero_d = empty_q;
      if (!empty_q) begin
        rp_d = rp_inc;
        if (rp_inc == wp_q) begin
          empty_d = 1'b1;
        end
      end
    end

    fill_diff = wp_d - rp_d;
    if (empty_d) begin
      cnt = '0;
    end else if (rp_d == wp_d) begin
      cnt = asp_pkg::CNT_W'(asp_pkg::FIFO_DEPTH);
    end else begin
      cnt = {1'b0, fill_diff};
    end

    res_o.sample_valid = is_tick;
    res_o.audio_sample = !is_tick ? '0 :
                         (state_q == asp_pkg::S_IDLE) ? audio_now : audio_q;
    res_o.irq          = cw_d[asp_pkg::CW_IRQ_EN] &&
                         (asp_pkg::CMP_W'(cnt) < asp_pkg::CMP_W'(thresh_i));
  end

  assign idle_o = (state_q == asp_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asp_pkg::S_IDLE;
      empty_q <= 1'b1;
      rp_q    <= '0;
      wp_q    <= '0;
      cw_q    <= '0;
      step_q  <= '0;
      lvl_q   <= '0;
      pend_q  <= '0;
      wait_q  <= '0;
      left_q  <= '0;
      rate_q  <= '0;
    end else begin
      state_q <= state_d;
      empty_q <= empty_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      cw_q    <= cw_d;
      step_q  <= step_d;
      lvl_q   <= lvl_d;
      pend_q  <= pend_d;
      wait_q  <= wait_d;
      left_q  <= left_d;
      rate_q  <= rate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    audio_q <= audio_d;
    sel_q   <= sel_d;
    zero_q  <= zero_d;
  end

endmodule

>>> hdl/adpcm_speech_fifo_player_top.sv
// A result reaches the output register in the cycle after its item is taken; a tick
// popping FIFO bytes runs S_NIB (nibble fetch), S_CMD (command), S_CMD, S_CNT (counted)
// or S_CMD, S_RATE, S_MUL (repeat). Throughput: 1 item per cycle unless the result
// waits unread or a popping tick holds input, reading bytes via the single RAM read port.
// Reset (async, active low): FIFO empty, pointers and decoder state cleared, threshold 48;
// the FIFO RAM itself is not cleared and the block takes items right after reset.
module adpcm_speech_fifo_player_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  asp_item_if.sink      item_i,
  asp_result_if.source  result_o,
  asp_cfg_if.sink       cfg_i
);

  logic [asp_pkg::THR_W-1:0] thr_q;
  logic                      out_valid_q;
  asp_pkg::res_t             out_q;
  asp_pkg::res_t             core_res;
  asp_pkg::item_t            item;
  logic                      core_idle;
  logic                      core_done;
  logic                      accept;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = core_idle && (!out_valid_q || result_o.ready);
  assign accept       = item_i.valid && item_i.ready;
  assign item         = '{action: item_i.action, write_value: item_i.write_value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= asp_pkg::THR_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      thr_q <= cfg_i.irq_level;
    end
  end

  asp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .thresh_i (thr_q),
    .idle_o   (core_idle),
    .done_o   (core_done),
    .res_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_q <= core_res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.read_data    = out_q.read_data;
  assign result_o.audio_sample = out_q.audio_sample;
  assign result_o.sample_valid = out_q.sample_valid;
  assign result_o.irq          = out_q.irq;

  // a multi-cycle tick finishes only into an empty output register
  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_done && !core_idle) |-> !out_valid_q)
    else $error("multi-cycle item finished while output register held a result");

  // an item that does not finish at once keeps the sequencer busy
  a_busy_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !core_done) |=> !core_idle)
    else $error("sequencer idle after an item left pending");

  // tick results never carry read data
  a_tick_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.sample_valid) |-> (result_o.read_data == '0))
    else $error("tick result with nonzero read data");

endmodule
